[design/battery_transmit_gate_macros.svh]
// Assertion helpers used by the checker file btg_checker.sv.
`ifndef BATTERY_TRANSMIT_GATE_MACROS_SVH
`define BATTERY_TRANSMIT_GATE_MACROS_SVH

// Check on every edge outside reset.
`define BTG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every edge, reset included.
`define BTG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/btg_pkg.sv]
`default_nettype none

package btg_pkg;

  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegCapVeryCold  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegCapCold      = 8'd1;
  localparam logic [CfgIdxW-1:0] RegCapNormal    = 8'd2;
  localparam logic [CfgIdxW-1:0] RegCapWarm      = 8'd3;
  localparam logic [CfgIdxW-1:0] RegPulseCurrent = 8'd4;
  localparam logic [CfgIdxW-1:0] RegCritVoltage  = 8'd5;
  localparam logic [CfgIdxW-1:0] RegWarnVoltage  = 8'd6;
  localparam logic [CfgIdxW-1:0] RegLowCharge    = 8'd7;

  localparam logic [23:0] CapVeryColdRst  = 24'd8300000;
  localparam logic [23:0] CapColdRst      = 24'd9400000;
  localparam logic [23:0] CapNormalRst    = 24'd10500000;
  localparam logic [23:0] CapWarmRst      = 24'd10500000;
  localparam logic [9:0]  PulseCurrentRst = 10'd500;
  localparam logic [12:0] CritVoltageRst  = 13'd2500;
  localparam logic [12:0] WarnVoltageRst  = 13'd2800;
  localparam logic [9:0]  LowChargeRst    = 10'd300;

  localparam logic signed [11:0] VeryColdLimit = -12'sd200;
  localparam logic signed [11:0] ColdLimit     = 12'sd0;
  localparam logic signed [11:0] NormalLimit   = 12'sd200;
  localparam logic [15:0] HighImpedanceMohm    = 16'd1500;
  localparam logic [9:0]  LowChargeWarn        = 10'd200;
  localparam logic [9:0]  PermilleFull         = 10'd1000;

  // ceil(2^36 / 1000); exact floor division for products below 2^26
  localparam logic [26:0] RecipDiv1000 = 27'd68719477;
  localparam int          RecipShift   = 36;

  typedef enum logic [1:0] {
    VerdictGo    = 2'd0,
    VerdictWarn  = 2'd1,
    VerdictBlock = 2'd2
  } btg_verdict_e;

  typedef struct packed {
    logic [12:0]        cell_voltage_mv;
    logic signed [11:0] temperature_decideg;
    logic [23:0]        used_charge_uah;
    logic [15:0]        resistance_mohm;
  } btg_in_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [9:0]  charge_permille;
    logic [23:0] band_capacity_uah;
    logic [12:0] loaded_voltage_mv;
  } btg_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } btg_cfg_word_t;

  typedef struct packed {
    logic [23:0] cap_very_cold;
    logic [23:0] cap_cold;
    logic [23:0] cap_normal;
    logic [23:0] cap_warm;
    logic [9:0]  pulse_current_ma;
    logic [12:0] critical_voltage_mv;
    logic [12:0] warning_voltage_mv;
    logic [9:0]  low_charge_permille;
  } btg_cfg_t;

  typedef struct packed {
    logic [33:0] num;
    logic [23:0] cap;
    logic        cap_zero;
    logic [12:0] voltage;
    logic [25:0] drop_prod;
    logic        cold;
    logic        very_cold;
    logic        warm_high_imp;
  } btg_job_t;

  typedef struct packed {
    logic [23:0] rem;
    logic [2:0]  quo;
  } btg_div3_t;

  // three restoring division steps, most significant bit first
  function automatic btg_div3_t div_step3(logic [23:0] rem, logic [2:0] bits,
                                          logic [23:0] dvs);
    logic [24:0] t;
    logic [24:0] diff;
    logic [23:0] r;
    btg_div3_t   res;
    r = rem;
    res.quo = '0;
    for (int i = 2; i >= 0; i--) begin
      t = {r, bits[i]};
      diff = t - {1'b0, dvs};
      if (t >= {1'b0, dvs}) begin
        r = diff[23:0];
        res.quo[i] = 1'b1;
      end else begin
        r = t[23:0];
      end
    end
    res.rem = r;
    return res;
  endfunction

endpackage

`default_nettype wire

[design/btg_if.sv]
`default_nettype none

interface btg_in_if;
  import btg_pkg::*;
  logic    valid;
  logic    ready;
  btg_in_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface btg_out_if;
  import btg_pkg::*;
  logic     valid;
  logic     ready;
  btg_out_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface btg_cfg_if;
  import btg_pkg::*;
  logic          valid;
  logic          ready;
  btg_cfg_word_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

[design/btg_cfg_regs.sv]
`default_nettype none

module btg_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  btg_cfg_if.sink           cfg_i,
  output btg_pkg::btg_cfg_t cfg_o
);
  import btg_pkg::*;

  btg_cfg_t regs_q;
  btg_cfg_t regs_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = regs_q;

  always_comb begin
    regs_d = regs_q;
    if (cfg_i.valid) begin
      case (cfg_i.word.index)
        RegCapVeryCold:  regs_d.cap_very_cold       = cfg_i.word.data[23:0];
        RegCapCold:      regs_d.cap_cold            = cfg_i.word.data[23:0];
        RegCapNormal:    regs_d.cap_normal          = cfg_i.word.data[23:0];
        RegCapWarm:      regs_d.cap_warm            = cfg_i.word.data[23:0];
        RegPulseCurrent: regs_d.pulse_current_ma    = cfg_i.word.data[9:0];
        RegCritVoltage:  regs_d.critical_voltage_mv = cfg_i.word.data[12:0];
        RegWarnVoltage:  regs_d.warning_voltage_mv  = cfg_i.word.data[12:0];
        RegLowCharge:    regs_d.low_charge_permille = cfg_i.word.data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.cap_very_cold       <= CapVeryColdRst;
      regs_q.cap_cold            <= CapColdRst;
      regs_q.cap_normal          <= CapNormalRst;
      regs_q.cap_warm            <= CapWarmRst;
      regs_q.pulse_current_ma    <= PulseCurrentRst;
      regs_q.critical_voltage_mv <= CritVoltageRst;
      regs_q.warning_voltage_mv  <= WarnVoltageRst;
      regs_q.low_charge_permille <= LowChargeRst;
    end else begin
      regs_q <= regs_d;
    end
  end

endmodule

`default_nettype wire

[design/btg_front.sv]
`default_nettype none

module btg_front (
  btg_in_if.sink            in_i,
  input  btg_pkg::btg_cfg_t cfg_i,
  input  logic              full_i,
  output logic              push_o,
  output btg_pkg::btg_job_t job_o
);
  import btg_pkg::*;

  logic        very_cold;
  logic        cold;
  logic        normal;
  logic [23:0] cap;
  logic [23:0] remaining;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  assign very_cold = in_i.word.temperature_decideg < VeryColdLimit;
  assign cold      = in_i.word.temperature_decideg < ColdLimit;
  assign normal    = in_i.word.temperature_decideg < NormalLimit;

  always_comb begin
    if (very_cold) begin
      cap = cfg_i.cap_very_cold;
    end else if (cold) begin
      cap = cfg_i.cap_cold;
    end else if (normal) begin
      cap = cfg_i.cap_normal;
    end else begin
      cap = cfg_i.cap_warm;
    end
  end

  assign remaining = (cap > in_i.word.used_charge_uah) ?
                     cap - in_i.word.used_charge_uah : '0;

  always_comb begin
    job_o.num           = 34'(remaining) * 34'(PermilleFull);
    job_o.cap           = cap;
    job_o.cap_zero      = (cap == '0);
    job_o.voltage       = in_i.word.cell_voltage_mv;
    job_o.drop_prod     = 26'(cfg_i.pulse_current_ma) * 26'(in_i.word.resistance_mohm);
    job_o.cold          = cold;
    job_o.very_cold     = very_cold;
    job_o.warm_high_imp = (in_i.word.resistance_mohm > HighImpedanceMohm) &&
                          (in_i.word.temperature_decideg > ColdLimit);
  end

endmodule

`default_nettype wire

[design/btg_queue.sv]
`default_nettype none

module btg_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  btg_pkg::btg_job_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output btg_pkg::btg_job_t data_o
);
  import btg_pkg::*;

  btg_job_t   mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic [1:0] cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[design/btg_back.sv]
`default_nettype none

module btg_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  btg_pkg::btg_cfg_t cfg_i,
  input  logic              valid_i,
  input  btg_pkg::btg_job_t job_i,
  output logic              pop_o,
  btg_out_if.source         out_o
);
  import btg_pkg::*;

  logic        busy_q;
  logic [1:0]  cnt_q;
  logic [23:0] rem_q;
  logic [11:0] bits_q;
  logic [11:0] quo_q;
  logic [23:0] cap_q;
  logic        cap_zero_q;
  logic [12:0] volt_q;
  logic [16:0] drop_q;
  logic [12:0] loaded_q;
  logic        cold_q;
  logic        very_cold_q;
  logic        warm_high_imp_q;

  logic        out_valid_q;
  btg_out_t    out_word_q;
  btg_out_t    out_word_d;

  logic        start;
  logic        last;
  logic        out_free;
  logic        fin_fire;
  logic        step_en;
  logic [23:0] step_rem;
  logic [2:0]  step_bits;
  logic [23:0] step_dvs;
  btg_div3_t   step_res;
  logic [52:0] drop_full;
  logic [12:0] loaded_d;
  logic [11:0] quo_full;
  logic [9:0]  charge;
  btg_verdict_e verdict;

  assign out_free = !out_valid_q || out_o.ready;
  assign start    = !busy_q && valid_i;
  assign last     = busy_q && (cnt_q == 2'd3);
  assign fin_fire = last && out_free;
  assign step_en  = start || (busy_q && !last) || fin_fire;
  assign pop_o    = start;

  assign step_rem  = busy_q ? rem_q : {2'b00, job_i.num[33:12]};
  assign step_bits = busy_q ? bits_q[11:9] : job_i.num[11:9];
  assign step_dvs  = busy_q ? cap_q : job_i.cap;
  assign step_res  = div_step3(step_rem, step_bits, step_dvs);

  assign drop_full = 53'(job_i.drop_prod) * 53'(RecipDiv1000);
  assign loaded_d  = ({4'b0, volt_q} > drop_q) ? volt_q - drop_q[12:0] : '0;

  assign quo_full = {quo_q[8:0], step_res.quo};
  assign charge   = cap_zero_q ? '0 : quo_full[9:0];

  always_comb begin
    if (loaded_q < cfg_i.critical_voltage_mv) begin
      verdict = VerdictBlock;
    end else if (cold_q && (charge < cfg_i.low_charge_permille)) begin
      verdict = VerdictBlock;
    end else if (very_cold_q && (loaded_q < cfg_i.warning_voltage_mv)) begin
      verdict = VerdictWarn;
    end else if (warm_high_imp_q) begin
      verdict = VerdictWarn;
    end else if (charge < LowChargeWarn) begin
      verdict = VerdictWarn;
    end else begin
      verdict = VerdictGo;
    end
  end

  always_comb begin
    out_word_d.verdict           = verdict;
    out_word_d.charge_permille   = charge;
    out_word_d.band_capacity_uah = cap_q;
    out_word_d.loaded_voltage_mv = loaded_q;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.word  = out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (start) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd1;
      end else if (fin_fire) begin
        busy_q <= 1'b0;
        cnt_q  <= 2'd0;
      end else if (busy_q && !last) begin
        cnt_q <= cnt_q + 2'd1;
      end
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      rem_q  <= step_res.rem;
      bits_q <= busy_q ? {bits_q[8:0], 3'b000} : {job_i.num[8:0], 3'b000};
      quo_q  <= busy_q ? quo_full : {9'b0, step_res.quo};
    end
    if (start) begin
      cap_q           <= job_i.cap;
      cap_zero_q      <= job_i.cap_zero;
      volt_q          <= job_i.voltage;
      drop_q          <= drop_full[RecipShift+16:RecipShift];
      cold_q          <= job_i.cold;
      very_cold_q     <= job_i.very_cold;
      warm_high_imp_q <= job_i.warm_high_imp;
    end
    if (busy_q && (cnt_q == 2'd1)) begin
      loaded_q <= loaded_d;
    end
    if (fin_fire) begin
      out_word_q <= out_word_d;
    end
  end

endmodule

`default_nettype wire

[design/battery_transmit_gate.sv]
// Transmit gate for a radio fed from a primary cell: go, warn or block.
// in_i   : one word per check (voltage, temperature, used charge, impedance).
// out_o  : one word per input word (verdict, charge per-mille, band capacity,
//          loaded voltage), in input order.
// cfg_i  : register writes (index, data); always ready; write only while idle.
// An accepted word passes the queue, the divider and the output register.
// The charge ratio divider takes one word at a time and resolves 3 quotient
// bits per cycle, but holds on its last step while the output is stalled.
// A 2-entry queue sits between the input classifier and the divider, so input
// words are taken while a result still waits at the output.
// Reset loads the default registers and empties queue, divider and output.
// When the receiver stalls the output register holds its word, the divider
// holds on its last step, the queue fills, and then in_i.ready drops.
`default_nettype none

module battery_transmit_gate (
  input  logic      clk_i,
  input  logic      rst_ni,
  btg_in_if.sink    in_i,
  btg_out_if.source out_o,
  btg_cfg_if.sink   cfg_i
);
  import btg_pkg::*;

  btg_cfg_t cfg;
  btg_job_t push_job;
  btg_job_t head_job;
  logic     push;
  logic     full;
  logic     pop;
  logic     head_valid;

  btg_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  btg_front u_front (
    .in_i   (in_i),
    .cfg_i  (cfg),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  btg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head_job)
  );

  btg_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (head_valid),
    .job_i   (head_job),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

[design/btg_checker.sv]
`default_nettype none
`include "battery_transmit_gate_macros.svh"

module btg_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input btg_pkg::btg_out_t out_word_i
);
  import btg_pkg::*;

  `BTG_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i), "stalled output word changed")
  `BTG_ASSERT(a_charge_range, out_valid_i |-> out_word_i.charge_permille <= PermilleFull, "charge above full scale")
  `BTG_ASSERT(a_low_charge_not_go, out_valid_i && (out_word_i.charge_permille < LowChargeWarn) |-> out_word_i.verdict != VerdictGo, "low charge passed as go")
  `BTG_ASSERT(a_zero_cap, out_valid_i && (out_word_i.band_capacity_uah == '0) |-> out_word_i.charge_permille == '0, "zero capacity gave nonzero charge")
  `BTG_ASSERT_ALWAYS(a_reset_empty, $rose(rst_ni) |-> !out_valid_i, "output valid coming out of reset")

endmodule

bind battery_transmit_gate btg_checker u_btg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_word_i  (out_o.word)
);

`default_nettype wire
